@@ sv/vsr_pkg.sv @@
// vsr_pkg: shared types and constants for the viewport scissor resolve block.
// Holds the request/response word structs, CSR index codes and pipeline sideband.
// No dependencies.
package vsr_pkg;

   localparam int PIXEL_BITS = 15;
   localparam int QUO_BITS   = PIXEL_BITS + 1;
   localparam int EXT_BITS   = 31;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X        = 3'd0,
      CSR_ORIGIN_Y        = 3'd1,
      CSR_EXTENT_X        = 3'd2,
      CSR_EXTENT_Y        = 3'd3,
      CSR_VIEWPORT_X      = 3'd4,
      CSR_VIEWPORT_Y      = 3'd5,
      CSR_VIEWPORT_WIDTH  = 3'd6,
      CSR_VIEWPORT_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                          clip_enabled;
      logic signed [15:0]            clip_x;
      logic signed [15:0]            clip_y;
      logic [15:0]                   clip_width;
      logic [15:0]                   clip_height;
      logic [PIXEL_BITS-1:0]         target_width;
      logic [PIXEL_BITS-1:0]         target_height;
   } req_type;

   typedef struct packed {
      logic                          accepted;
      logic [PIXEL_BITS-1:0]         scissor_x;
      logic [PIXEL_BITS-1:0]         scissor_y;
      logic [PIXEL_BITS-1:0]         scissor_width;
      logic [PIXEL_BITS-1:0]         scissor_height;
   } rsp_type;

   typedef struct packed {
      logic                          reject;
      logic [PIXEL_BITS-1:0]         tw;
      logic [PIXEL_BITS-1:0]         th;
   } side_type;

endpackage

@@ sv/vsr_div_lane.sv @@
// vsr_div_lane: pipelined floor division of a signed numerator by an unsigned
// divisor, quotient saturated to QW bits of magnitude. One quotient bit a stage.
// Depends on vsr_pkg.
module vsr_div_lane import vsr_pkg::*; #(
   parameter int NW = 52,
   parameter int QW = 16
) (
   input  logic                 clock,
   input  logic [QW:0]          load,
   input  logic signed [NW-1:0] num,
   input  logic [EXT_BITS-1:0]  den,
   output logic signed [QW:0]   quo
);

   localparam int RW = EXT_BITS + QW;

   logic [RW-1:0] rem_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic          neg_ff [0:QW];
   logic          sat_ff [0:QW];

   logic [NW-1:0] mag;
   logic [NW-2:0] lim;
   logic [QW-1:0] q_fin;

   // floor(n/d) for n<0 is ~floor(~n/d)
   assign mag = num[NW-1] ? ~num : num;
   assign lim = (NW-1)'(den) << QW;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rem_ff[0] <= mag[RW-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= num[NW-1];
         sat_ff[0] <= (mag[NW-2:0] >= lim);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int B = QW - 1 - k;
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = RW'(den) << B;
      assign ge  = (rem_ff[k] >= dsh);
      always_ff @(posedge clock) begin
         if (load[k+1]) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - dsh : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (QW'(ge) << B);
            neg_ff[k+1] <= neg_ff[k];
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   assign q_fin = sat_ff[QW] ? '1 : q_ff[QW];
   assign quo   = neg_ff[QW] ? ~{1'b0, q_fin} : {1'b0, q_fin};

endmodule

@@ sv/viewport_scissor_resolve.sv @@
// viewport_scissor_resolve: maps a draw request's clip rectangle to a pixel scissor.
// A word passes PIXEL_BITS+6 register stages from request accept to rsp_valid: edge
// setup, multiply, divider load, one stage per quotient bit of the four divider lanes,
// clamp, output register. Throughput one word per cycle unless rsp_ready stalls it;
// stages advance independently so bubbles collapse.
// Synchronous active-high reset clears the valid bits and loads the CSR defaults.
// Depends on vsr_pkg and vsr_div_lane.
module viewport_scissor_resolve import vsr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [31:0]           csr_data
);

   localparam int QW  = QUO_BITS;
   localparam int DW  = ((FRAC_BITS + 18 > 32) ? FRAC_BITS + 18 : 32) + 2;
   localparam int NW  = DW + PIXEL_BITS + 1;
   localparam int SW  = QW + 3;
   localparam int S_CLAMP = QW + 3;
   localparam int NS  = QW + 5;

   logic signed [31:0]        origin_x_ff, origin_y_ff;
   logic [EXT_BITS-1:0]       extent_x_ff, extent_y_ff;
   logic signed [15:0]        viewport_x_ff, viewport_y_ff;
   logic [PIXEL_BITS-1:0]     viewport_width_ff, viewport_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff        <= '0;
         origin_y_ff        <= '0;
         extent_x_ff        <= EXT_BITS'(65536);
         extent_y_ff        <= EXT_BITS'(65536);
         viewport_x_ff      <= '0;
         viewport_y_ff      <= '0;
         viewport_width_ff  <= '0;
         viewport_height_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORIGIN_X:        origin_x_ff        <= csr_data;
            CSR_ORIGIN_Y:        origin_y_ff        <= csr_data;
            CSR_EXTENT_X:        extent_x_ff        <= csr_data[EXT_BITS-1:0];
            CSR_EXTENT_Y:        extent_y_ff        <= csr_data[EXT_BITS-1:0];
            CSR_VIEWPORT_X:      viewport_x_ff      <= csr_data[15:0];
            CSR_VIEWPORT_Y:      viewport_y_ff      <= csr_data[15:0];
            CSR_VIEWPORT_WIDTH:  viewport_width_ff  <= csr_data[PIXEL_BITS-1:0];
            CSR_VIEWPORT_HEIGHT: viewport_height_ff <= csr_data[PIXEL_BITS-1:0];
         endcase
      end
   end

   // stage handshake
   logic [NS-1:0] valid_ff;
   logic [NS:0]   can_load;

   always_comb begin
      can_load[NS] = rsp_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         can_load[i] = !valid_ff[i] || can_load[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (can_load[i]) begin
               valid_ff[i] <= (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_ready = can_load[0];
   assign rsp_valid = valid_ff[NS-1];

   // stage 0: checks and edge offsets
   logic signed [DW-1:0] ox_w, oy_w, ex_w, ey_w, cx_w, cy_w;
   logic signed [DW-1:0] ll, lt, lr, lb;
   logic [PIXEL_BITS:0]  vx_end, vy_end;
   logic                 reject_in;
   side_type             side_in;

   assign ox_w = DW'(origin_x_ff);
   assign oy_w = DW'(origin_y_ff);
   assign ex_w = DW'(signed'({1'b0, extent_x_ff}));
   assign ey_w = DW'(signed'({1'b0, extent_y_ff}));
   assign cx_w = DW'(req_data.clip_x);
   assign cy_w = DW'(req_data.clip_y);

   always_comb begin
      if (req_data.clip_enabled) begin
         ll = cx_w <<< FRAC_BITS;
         lt = cy_w <<< FRAC_BITS;
         lr = (cx_w + DW'(signed'({1'b0, req_data.clip_width}))) <<< FRAC_BITS;
         lb = (cy_w + DW'(signed'({1'b0, req_data.clip_height}))) <<< FRAC_BITS;
      end else begin
         ll = ox_w;
         lt = oy_w;
         lr = ox_w + ex_w;
         lb = oy_w + ey_w;
      end
   end

   assign vx_end = (PIXEL_BITS+1)'(viewport_x_ff[PIXEL_BITS-1:0])
                 + (PIXEL_BITS+1)'(viewport_width_ff);
   assign vy_end = (PIXEL_BITS+1)'(viewport_y_ff[PIXEL_BITS-1:0])
                 + (PIXEL_BITS+1)'(viewport_height_ff);

   assign reject_in = (extent_x_ff == '0) || (extent_y_ff == '0)
                   || (viewport_width_ff == '0) || (viewport_height_ff == '0)
                   || (req_data.target_width == '0) || (req_data.target_height == '0)
                   || viewport_x_ff[15] || viewport_y_ff[15]
                   || (vx_end > (PIXEL_BITS+1)'(req_data.target_width))
                   || (vy_end > (PIXEL_BITS+1)'(req_data.target_height))
                   || (req_data.clip_enabled
                       && ((req_data.clip_width == '0) || (req_data.clip_height == '0)));

   assign side_in = '{reject: reject_in, tw: req_data.target_width,
                      th: req_data.target_height};

   logic signed [DW-1:0] diff_ff [0:3];
   logic signed [NW-1:0] num_ff  [0:3];
   side_type             side_ff [0:S_CLAMP-1];

   always_ff @(posedge clock) begin
      if (can_load[0]) begin
         diff_ff[0] <= ll - ox_w;
         diff_ff[1] <= ox_w - lr;
         diff_ff[2] <= lt - oy_w;
         diff_ff[3] <= oy_w - lb;
         side_ff[0] <= side_in;
      end
      for (int i = 1; i < S_CLAMP; i++) begin
         if (can_load[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // stage 1: scale by viewport size; stages 2..QW+2: divider lanes
   logic signed [QW:0] quo [0:3];

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic signed [NW-1:0] scale;
      assign scale = (l < 2) ? NW'(signed'({1'b0, viewport_width_ff}))
                             : NW'(signed'({1'b0, viewport_height_ff}));
      always_ff @(posedge clock) begin
         if (can_load[1]) begin
            num_ff[l] <= NW'(diff_ff[l]) * scale;
         end
      end
      vsr_div_lane #(.NW(NW), .QW(QW)) u_div (
         .clock (clock),
         .load  (can_load[QW+2:2]),
         .num   (num_ff[l]),
         .den   ((l < 2) ? extent_x_ff : extent_y_ff),
         .quo   (quo[l])
      );
   end

   // clamp stage
   function automatic logic [PIXEL_BITS-1:0] clamp_px(input logic signed [SW-1:0] s,
                                                       input logic [PIXEL_BITS-1:0] hi);
      logic [PIXEL_BITS-1:0] r;
      if (s < 0) r = '0;
      else if (s > SW'(signed'({1'b0, hi}))) r = hi;
      else r = s[PIXEL_BITS-1:0];
      return r;
   endfunction

   logic [PIXEL_BITS-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic                  rej_ff;

   always_ff @(posedge clock) begin
      if (can_load[S_CLAMP]) begin
         x0_ff  <= clamp_px(SW'(viewport_x_ff) + SW'(quo[0]), side_ff[S_CLAMP-1].tw);
         x1_ff  <= clamp_px(SW'(viewport_x_ff) - SW'(quo[1]), side_ff[S_CLAMP-1].tw);
         y0_ff  <= clamp_px(SW'(viewport_y_ff) + SW'(quo[2]), side_ff[S_CLAMP-1].th);
         y1_ff  <= clamp_px(SW'(viewport_y_ff) - SW'(quo[3]), side_ff[S_CLAMP-1].th);
         rej_ff <= side_ff[S_CLAMP-1].reject;
      end
   end

   // output register
   rsp_type rsp_ff;
   logic    bad;

   assign bad = rej_ff || (x1_ff <= x0_ff) || (y1_ff <= y0_ff);

   always_ff @(posedge clock) begin
      if (can_load[NS-1]) begin
         if (bad) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.accepted       <= 1'b1;
            rsp_ff.scissor_x      <= x0_ff;
            rsp_ff.scissor_y      <= y0_ff;
            rsp_ff.scissor_width  <= x1_ff - x0_ff;
            rsp_ff.scissor_height <= y1_ff - y0_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ sv/vsr_checker.sv @@
// vsr_checker: port-level assertions for viewport_scissor_resolve, bound to the top.
// Depends on vsr_pkg.
module vsr_checker import vsr_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input rsp_type       rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> rsp_data == '0)
      else $error("rejected word carries non-zero fields");

   a_accept_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |->
         rsp_data.scissor_width != '0 && rsp_data.scissor_height != '0)
      else $error("accepted word with empty rectangle");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind viewport_scissor_resolve vsr_checker u_vsr_checker (.*);

@@ tb/sv/vsr_checker.sv @@
// vsr_scoreboard: watches the request, response and CSR channels of viewport_scissor_resolve,
// predicts each response word from its own copy of the CSRs and compares in order.
// Depends on vsr_pkg.
module vsr_scoreboard import vsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  req_type       req_data,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  rsp_type       rsp_data,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data,
   output int            errors,
   output int            pending
);

   logic signed [31:0] org_x, org_y;
   logic [30:0]        ext_x, ext_y;
   logic signed [15:0] vp_x, vp_y;
   logic [14:0]        vp_w, vp_h;
   rsp_type            scissor_q[$];

   function automatic longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp(longint v, longint hi);
      if (v < 0) return 0;
      return (v > hi) ? hi : v;
   endfunction

   function automatic rsp_type predict_word(req_type r);
      rsp_type res;
      longint  ox, oy, ex, ey, vx, vy, vw, vh, tw, th, cx, cy;
      longint  ll, lt, lr, lb, x0, y0, x1, y1;
      res = '0;
      ox = org_x; oy = org_y; ex = ext_x; ey = ext_y;
      vx = vp_x; vy = vp_y; vw = vp_w; vh = vp_h;
      tw = r.target_width; th = r.target_height;
      cx = r.clip_x; cy = r.clip_y;
      if (ex == 0 || ey == 0 || vw == 0 || vh == 0 || tw == 0 || th == 0) return res;
      if (vx < 0 || vy < 0 || vx + vw > tw || vy + vh > th) return res;
      if (r.clip_enabled && (r.clip_width == 0 || r.clip_height == 0)) return res;
      if (r.clip_enabled) begin
         ll = cx * 65536;
         lt = cy * 65536;
         lr = (cx + longint'(r.clip_width)) * 65536;
         lb = (cy + longint'(r.clip_height)) * 65536;
      end else begin
         ll = ox; lt = oy; lr = ox + ex; lb = oy + ey;
      end
      x0 = clamp(vx + fdiv((ll - ox) * vw, ex), tw);
      y0 = clamp(vy + fdiv((lt - oy) * vh, ey), th);
      x1 = clamp(vx - fdiv(-((lr - ox) * vw), ex), tw);
      y1 = clamp(vy - fdiv(-((lb - oy) * vh), ey), th);
      if (x1 <= x0 || y1 <= y0) return res;
      res.accepted       = 1'b1;
      res.scissor_x      = x0[PIXEL_BITS-1:0];
      res.scissor_y      = y0[PIXEL_BITS-1:0];
      res.scissor_width  = PIXEL_BITS'(x1 - x0);
      res.scissor_height = PIXEL_BITS'(y1 - y0);
      return res;
   endfunction

   assign pending = scissor_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         org_x <= '0; org_y <= '0; ext_x <= 31'd65536; ext_y <= 31'd65536;
         vp_x <= '0; vp_y <= '0; vp_w <= '0; vp_h <= '0;
         scissor_q.delete();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:        org_x <= csr_data;
               CSR_ORIGIN_Y:        org_y <= csr_data;
               CSR_EXTENT_X:        ext_x <= csr_data[30:0];
               CSR_EXTENT_Y:        ext_y <= csr_data[30:0];
               CSR_VIEWPORT_X:      vp_x <= csr_data[15:0];
               CSR_VIEWPORT_Y:      vp_y <= csr_data[15:0];
               CSR_VIEWPORT_WIDTH:  vp_w <= csr_data[14:0];
               CSR_VIEWPORT_HEIGHT: vp_h <= csr_data[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) scissor_q.push_back(predict_word(req_data));
         if (rsp_valid && rsp_ready) begin
            if (scissor_q.size() == 0) begin
               $error("response word with nothing expected");
               errors <= errors + 1;
            end else begin
               want = scissor_q.pop_front();
               if (want != rsp_data) errors <= errors + 1;
               if (want.accepted != rsp_data.accepted)
                  $error("accepted: exp %0d got %0d", want.accepted, rsp_data.accepted);
               if (want.scissor_x != rsp_data.scissor_x)
                  $error("scissor_x: exp %0d got %0d", want.scissor_x, rsp_data.scissor_x);
               if (want.scissor_y != rsp_data.scissor_y)
                  $error("scissor_y: exp %0d got %0d", want.scissor_y, rsp_data.scissor_y);
               if (want.scissor_width != rsp_data.scissor_width)
                  $error("scissor_width: exp %0d got %0d", want.scissor_width,
                         rsp_data.scissor_width);
               if (want.scissor_height != rsp_data.scissor_height)
                  $error("scissor_height: exp %0d got %0d", want.scissor_height,
                         rsp_data.scissor_height);
            end
         end
      end
   end

endmodule

@@ tb/sv/tb.sv @@
// tb: stimulus and verdict for viewport_scissor_resolve.
// Drives random CSR settings and draw requests with random gaps and stalls; checking
// is done by vsr_scoreboard. Depends on vsr_pkg, vsr_scoreboard and the block itself.
module tb;
   import vsr_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0, req_ready;
   req_type       req_data = '0;
   logic          rsp_valid, rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0, csr_ready;
   csr_index_type csr_index = CSR_ORIGIN_X;
   logic [31:0]   csr_data = '0;
   int            errors, pending;
   bit            quiet = 1'b0;
   int            stall_left = 0;
   logic [15:0]   cur_vx, cur_vy;
   logic [14:0]   cur_vw, cur_vh;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   viewport_scissor_resolve u_dut (.*);

   vsr_scoreboard u_chk (.*);

   initial begin
      #50_000_000;
      $display("tb: done, errors");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0)
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
      end
   end

   function automatic int pick_gap();
      if (quiet || $urandom_range(0, 2) != 0) return 0;
      return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
   endfunction

   task automatic send_word(req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VIEWPORT_X:      cur_vx = value[15:0];
         CSR_VIEWPORT_Y:      cur_vy = value[15:0];
         CSR_VIEWPORT_WIDTH:  cur_vw = value[14:0];
         CSR_VIEWPORT_HEIGHT: cur_vh = value[14:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [31:0] rnd_origin();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom();
         default: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
      endcase
   endfunction

   function automatic logic [31:0] rnd_extent();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'h7fff_ffff;
         3: return $urandom();
         default: return $urandom_range(1, 200) << 16;
      endcase
   endfunction

   function automatic logic [31:0] rnd_vpos();
      case ($urandom_range(0, 9))
         0: return 32'h0000_c000;
         1: return 32'd16384;
         2: return $urandom_range(0, 65535);
         3: return 32'd0;
         default: return $urandom_range(0, 100);
      endcase
   endfunction

   function automatic logic [31:0] rnd_vsize();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd16384;
         3: return $urandom_range(0, 32767);
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   function automatic logic [14:0] rnd_target(logic [15:0] pos, logic [14:0] size);
      int need;
      need = int'(pos) + int'(size) + $urandom_range(0, 200);
      if (pos[15] || need > 32767 || $urandom_range(0, 4) == 0)
         return 15'($urandom_range(0, 32767));
      return 15'(need);
   endfunction

   function automatic req_type rnd_request();
      req_type r;
      r.clip_enabled = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) begin
         r.clip_x = 16'($urandom()); r.clip_y = 16'($urandom());
         r.clip_width = 16'($urandom()); r.clip_height = 16'($urandom());
      end else begin
         r.clip_x = 16'($urandom_range(0, 400) - 200);
         r.clip_y = 16'($urandom_range(0, 400) - 200);
         r.clip_width  = 16'($urandom_range(0, 300));
         r.clip_height = 16'($urandom_range(0, 300));
      end
      r.target_width  = rnd_target(cur_vx, cur_vw);
      r.target_height = rnd_target(cur_vy, cur_vh);
      return r;
   endfunction

   function automatic req_type make_req(bit en, int x, int y, int w, int h, int tw, int th);
      req_type r;
      r.clip_enabled = en;
      r.clip_x = 16'(x); r.clip_y = 16'(y); r.clip_width = 16'(w); r.clip_height = 16'(h);
      r.target_width = 15'(tw); r.target_height = 15'(th);
      return r;
   endfunction

   initial begin
      cur_vx = '0; cur_vy = '0; cur_vw = '0; cur_vh = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: empty viewport, every word rejected
      repeat (3) send_word(rnd_request());
      drain();

      csr_write(CSR_ORIGIN_X, 32'd0);
      csr_write(CSR_ORIGIN_Y, 32'd0);
      csr_write(CSR_EXTENT_X, 32'd100 << 16);
      csr_write(CSR_EXTENT_Y, 32'd100 << 16);
      csr_write(CSR_VIEWPORT_X, 32'd10);
      csr_write(CSR_VIEWPORT_Y, 32'd20);
      csr_write(CSR_VIEWPORT_WIDTH, 32'd640);
      csr_write(CSR_VIEWPORT_HEIGHT, 32'd480);
      send_word(make_req(0, 0, 0, 0, 0, 1000, 1000));
      send_word(make_req(1, 10, 10, 33, 17, 1000, 1000));
      send_word(make_req(1, 10, 10, 0, 17, 1000, 1000));
      send_word(make_req(1, 10, 10, 33, 0, 1000, 1000));
      send_word(make_req(1, 10, 10, 33, 17, 0, 1000));
      send_word(make_req(1, 10, 10, 33, 17, 1000, 0));
      send_word(make_req(1, 10, 10, 33, 17, 600, 1000));
      send_word(make_req(1, 10, 10, 33, 17, 1000, 400));
      send_word(make_req(1, -32768, -32768, 65535, 65535, 32767, 32767));
      send_word(make_req(1, 32767, 32767, 65535, 65535, 32767, 32767));
      send_word(make_req(1, 500, 10, 20, 20, 1000, 1000));
      send_word(make_req(1, -50, -50, 20, 20, 1000, 1000));
      send_word(make_req(1, 99, 99, 1, 1, 650, 500));
      send_word(make_req(0, -1, -1, 65535, 65535, 32767, 32767));
      drain();

      csr_write(CSR_VIEWPORT_X, 32'h0000_ffff);
      send_word(make_req(0, 0, 0, 0, 0, 1000, 1000));
      drain();
      csr_write(CSR_VIEWPORT_X, 32'd0);
      csr_write(CSR_EXTENT_X, 32'd0);
      send_word(make_req(0, 0, 0, 0, 0, 1000, 1000));
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         quiet = (phase % 4 == 3);
         csr_write(CSR_ORIGIN_X, rnd_origin());
         csr_write(CSR_ORIGIN_Y, rnd_origin());
         csr_write(CSR_EXTENT_X, rnd_extent());
         csr_write(CSR_EXTENT_Y, rnd_extent());
         csr_write(CSR_VIEWPORT_X, rnd_vpos());
         csr_write(CSR_VIEWPORT_Y, rnd_vpos());
         csr_write(CSR_VIEWPORT_WIDTH, rnd_vsize());
         csr_write(CSR_VIEWPORT_HEIGHT, rnd_vsize());
         repeat (100) send_word(rnd_request());
         drain();
      end

      if (errors == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         if (pending != 0) $error("%0d expected words never arrived", pending);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
